/* rtl/core/alm_pkg.sv */
// shared types and codes for the linked multimap
package alm_pkg;

	localparam int unsigned KeyW = 32;
	localparam int unsigned ValW = 32;
	localparam int unsigned CntW = 6;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_KEYS   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_ADD_LINK,
		S_WALK_RD,
		S_WALK_CHK,
		S_SCAN,
		S_RM_A,
		S_RM_B,
		S_EMIT,
		S_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;        // capture request
		logic add_alloc;   // write slot at free head
		logic add_link;    // link previous tail to new slot
		logic walk_start;  // cursor to list head
		logic walk_read;   // read slot at cursor
		logic walk_adv;    // cursor to next link
		logic scan_start;  // start seen-key scan
		logic scan_step;   // next seen entry
		logic seen_push;   // append current key to seen list
		logic rm_a;        // unlink step one
		logic rm_b;        // unlink step two
		logic hold_load;   // park current data item in the hold register
		logic res_load;    // load result register
		logic res_hold;    // result takes the parked data item
		logic [1:0] res_status;
		logic res_key;     // parked item carries the slot key
		logic res_value;   // parked item carries the slot value
		logic res_last;
	} alm_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic full;
		logic cur_valid;    // cursor is a slot and step budget left
		logic key_match;
		logic pair_match;
		logic scan_done;
		logic scan_hit;
		logic hold_valid;   // a data item waits in the hold register
		logic out_busy;     // result register holds an unsent result
	} alm_sts_t;

endpackage

/* rtl/core/alm_datapath.sv */
// slot memories, links, walk cursor, seen-key store and result register
module alm_datapath #(
	parameter int unsigned SLOT_COUNT = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  alm_pkg::alm_cmd_t cmd,
	output alm_pkg::alm_sts_t sts,
	input  logic [31:0] in_key,
	input  logic [31:0] in_value,
	output logic res_valid,
	input  logic res_ready,
	output logic [71:0] res_data,
	output logic res_last
);
	import alm_pkg::*;

	localparam int unsigned LW = $clog2(SLOT_COUNT + 1);
	localparam int unsigned IW = $clog2(SLOT_COUNT);
	localparam logic [LW-1:0] NIL = LW'(SLOT_COUNT);

	logic [KeyW-1:0] key_mem [SLOT_COUNT];
	logic [ValW-1:0] val_mem [SLOT_COUNT];
	logic [KeyW-1:0] seen_mem [SLOT_COUNT];
	logic [LW-1:0]   next_q [SLOT_COUNT];
	logic [LW-1:0]   prev_q [SLOT_COUNT];

	logic [LW-1:0] head_q, tail_q, free_q, cur_q, new_q;
	logic [LW-1:0] cnt_q;
	logic [LW:0]   steps_q;
	logic [KeyW-1:0] req_key_q, rd_key_q, seen_rd_q;
	logic [ValW-1:0] req_val_q, rd_val_q;
	logic [LW-1:0] rd_next_q, rd_prev_q;
	logic [LW-1:0] seen_n_q, scan_q;
	logic [IW-1:0] scan_nx;
	logic hv_q;
	logic [KeyW-1:0] h_key_q;
	logic [ValW-1:0] h_val_q;
	logic ov_q;
	logic [1:0] o_st_q;
	logic [KeyW-1:0] o_key_q;
	logic [ValW-1:0] o_val_q;
	logic o_last_q;

	function automatic logic is_slot(input logic [LW-1:0] s);
		return s < NIL;
	endfunction

	assign scan_nx = scan_q[IW-1:0] + 1'b1;

	assign sts.full        = !is_slot(free_q);
	assign sts.cur_valid   = is_slot(cur_q) && (steps_q < (LW+1)'(SLOT_COUNT));
	assign sts.key_match   = rd_key_q == req_key_q;
	assign sts.pair_match  = (rd_key_q == req_key_q) && (rd_val_q == req_val_q);
	assign sts.scan_done   = scan_q >= seen_n_q;
	assign sts.scan_hit    = seen_rd_q == rd_key_q;
	assign sts.hold_valid  = hv_q;
	assign sts.out_busy    = ov_q;

	// memories: one write port each, registered reads
	always_ff @(posedge clk) begin
		if (cmd.add_alloc) begin
			key_mem[free_q[IW-1:0]] <= req_key_q;
			val_mem[free_q[IW-1:0]] <= req_val_q;
		end
		if (cmd.walk_read) begin
			rd_key_q <= key_mem[cur_q[IW-1:0]];
			rd_val_q <= val_mem[cur_q[IW-1:0]];
		end
		if (cmd.seen_push)
			seen_mem[seen_n_q[IW-1:0]] <= rd_key_q;
		if (cmd.scan_start || cmd.scan_step)
			seen_rd_q <= seen_mem[cmd.scan_start ? '0 : scan_nx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				next_q[i] <= LW'(i + 1);
				prev_q[i] <= NIL;
			end
			head_q <= NIL;
			tail_q <= NIL;
			free_q <= '0;
			cnt_q <= '0;
			cur_q <= NIL;
			new_q <= NIL;
			steps_q <= '0;
			seen_n_q <= '0;
			scan_q <= '0;
			hv_q <= 1'b0;
			ov_q <= 1'b0;
			rd_next_q <= NIL;
			rd_prev_q <= NIL;
			req_key_q <= '0;
			req_val_q <= '0;
		end else begin
			if (cmd.load) begin
				req_key_q <= in_key;
				req_val_q <= in_value;
				hv_q <= 1'b0;
				seen_n_q <= '0;
			end
			if (cmd.hold_load)
				hv_q <= 1'b1;
			if (cmd.add_alloc) begin
				new_q <= free_q;
				free_q <= next_q[free_q[IW-1:0]];
				next_q[free_q[IW-1:0]] <= NIL;
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.add_link) begin
				if (!is_slot(head_q) || !is_slot(tail_q)) begin
					head_q <= new_q;
					prev_q[new_q[IW-1:0]] <= NIL;
				end else begin
					next_q[tail_q[IW-1:0]] <= new_q;
					prev_q[new_q[IW-1:0]] <= tail_q;
				end
				tail_q <= new_q;
			end
			if (cmd.walk_start) begin
				cur_q <= head_q;
				steps_q <= '0;
			end
			if (cmd.walk_read) begin
				rd_next_q <= next_q[cur_q[IW-1:0]];
				rd_prev_q <= prev_q[cur_q[IW-1:0]];
			end
			if (cmd.walk_adv) begin
				cur_q <= rd_next_q;
				steps_q <= steps_q + 1'b1;
			end
			if (cmd.scan_start)
				scan_q <= '0;
			if (cmd.scan_step)
				scan_q <= scan_q + 1'b1;
			if (cmd.seen_push)
				seen_n_q <= seen_n_q + 1'b1;
			if (cmd.rm_a) begin
				if (cur_q == head_q || !is_slot(rd_prev_q)) begin
					head_q <= rd_next_q;
					if (is_slot(rd_next_q))
						prev_q[rd_next_q[IW-1:0]] <= NIL;
				end else begin
					next_q[rd_prev_q[IW-1:0]] <= rd_next_q;
					if (is_slot(rd_next_q))
						prev_q[rd_next_q[IW-1:0]] <= rd_prev_q;
				end
				next_q[cur_q[IW-1:0]] <= free_q;
				free_q <= cur_q;
				if (cnt_q != '0)
					cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.rm_b) begin
				if (!is_slot(rd_next_q))
					tail_q <= is_slot(head_q) ? rd_prev_q : NIL;
			end
			if (cmd.res_load)
				ov_q <= 1'b1;
			else if (res_ready)
				ov_q <= 1'b0;
		end
	end

	// hold register keeps a data item until its last flag is known
	always_ff @(posedge clk) begin
		if (cmd.hold_load) begin
			h_key_q <= cmd.res_key ? rd_key_q : '0;
			h_val_q <= cmd.res_value ? rd_val_q : '0;
		end
		if (cmd.res_load) begin
			o_st_q <= cmd.res_status;
			o_key_q <= cmd.res_hold ? h_key_q : '0;
			o_val_q <= cmd.res_hold ? h_val_q : '0;
			o_last_q <= cmd.res_last;
		end
	end

	assign res_valid = ov_q;
	assign res_last = o_last_q;
	assign res_data = {CntW'(cnt_q), o_val_q, o_key_q, o_st_q};
endmodule

/* rtl/core/alm_ctrl.sv */
// sequencer for add, remove, search and key listing
module alm_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] in_action,
	input  alm_pkg::alm_sts_t sts,
	output alm_pkg::alm_cmd_t cmd
);
	import alm_pkg::*;

	state_t state_q, state_d;
	action_t act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= ACT_ADD;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready)
				act_q <= action_t'(in_action);
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) begin
				case (action_t'(in_action))
					ACT_ADD: state_d = S_ADD;
					default: state_d = S_WALK_RD;
				endcase
			end
			S_ADD: if (!sts.out_busy)
				state_d = sts.full ? S_IDLE : S_ADD_LINK;
			S_ADD_LINK: state_d = S_IDLE;
			S_WALK_RD: state_d = sts.cur_valid ? S_WALK_CHK : S_DONE;
			S_WALK_CHK: begin
				case (act_q)
					ACT_REMOVE: state_d = sts.pair_match ? S_RM_A : S_WALK_RD;
					ACT_SEARCH: state_d = sts.key_match ? S_EMIT : S_WALK_RD;
					default:    state_d = S_SCAN;
				endcase
			end
			S_SCAN: begin
				if (sts.scan_done)
					state_d = S_EMIT;
				else if (sts.scan_hit)
					state_d = S_WALK_RD;
			end
			S_EMIT: if (!sts.out_busy) state_d = S_WALK_RD;
			S_RM_A: if (!sts.out_busy) state_d = S_RM_B;
			S_RM_B: if (!sts.out_busy) state_d = S_IDLE;
			S_DONE: if (!sts.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				cmd.walk_start = in_valid;
			end
			S_ADD: if (!sts.out_busy) begin
				cmd.res_load = 1'b1;
				cmd.res_last = 1'b1;
				if (sts.full)
					cmd.res_status = ST_FULL;
				else
					cmd.add_alloc = 1'b1;
			end
			S_ADD_LINK: cmd.add_link = 1'b1;
			S_WALK_RD: cmd.walk_read = sts.cur_valid;
			S_WALK_CHK: begin
				case (act_q)
					ACT_REMOVE: cmd.walk_adv = !sts.pair_match;
					ACT_SEARCH: cmd.walk_adv = !sts.key_match;
					default:    cmd.scan_start = 1'b1;
				endcase
			end
			S_SCAN: begin
				if (!sts.scan_done && !sts.scan_hit)
					cmd.scan_step = 1'b1;
				else if (!sts.scan_done)
					cmd.walk_adv = 1'b1;
			end
			// park the new item, send the one parked before it
			S_EMIT: if (!sts.out_busy) begin
				cmd.hold_load = 1'b1;
				cmd.res_load = sts.hold_valid;
				cmd.res_hold = 1'b1;
				cmd.walk_adv = 1'b1;
				if (act_q == ACT_SEARCH)
					cmd.res_value = 1'b1;
				else begin
					cmd.res_key = 1'b1;
					cmd.seen_push = 1'b1;
				end
			end
			S_RM_A: cmd.rm_a = !sts.out_busy;
			S_RM_B: if (!sts.out_busy) begin
				cmd.rm_b = 1'b1;
				cmd.res_load = 1'b1;
				cmd.res_last = 1'b1;
			end
			S_DONE: if (!sts.out_busy) begin
				cmd.res_load = 1'b1;
				cmd.res_last = 1'b1;
				if (sts.hold_valid)
					cmd.res_hold = 1'b1;
				else
					cmd.res_status = ST_NOTFOUND;
			end
			default: cmd = '0;
		endcase
	end
endmodule

/* rtl/core/array_linked_multimap.sv */
// top level of the array-backed linked multimap
// add: the answer is loaded in S_ADD, the new slot is linked in S_ADD_LINK, then the input is free
// remove, search and key listing walk the list slot by slot (read, then check); a search match
//   adds an emit step, key listing adds a compare per seen key and an emit step per new key
// a data result leaves once the next match or the walk end is known; output stalls hold the sequencer
// reset (arst_n low) empties the list and chains every slot onto the free list at once
module array_linked_multimap #(
	parameter int unsigned SLOT_COUNT = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [71:0] s_tdata,   // action[1:0], key[33:2], value[65:34], zero pad
	output logic m_tvalid,
	input  logic m_tready,
	output logic [71:0] m_tdata,   // status[1:0], out_key[33:2], out_value[65:34],
	                               // pair_count[71:66]
	output logic m_tlast
);
	import alm_pkg::*;

	alm_cmd_t cmd;
	alm_sts_t sts;
	logic [71:0] res_data;

	// one request at a time: the controller takes the next only from idle
	alm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_action(s_tdata[1:0]),
		.sts(sts), .cmd(cmd)
	);

	alm_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .sts(sts),
		.in_key(s_tdata[33:2]),
		.in_value(s_tdata[65:34]),
		.res_valid(m_tvalid), .res_ready(m_tready),
		.res_data(res_data), .res_last(m_tlast)
	);

	assign m_tdata = res_data;
endmodule

/* bench/testbench.sv */
// self-checking bench for the array-backed linked multimap
`timescale 1ns / 1ps

module testbench;
	import alm_pkg::*;

	localparam int unsigned SLOTS = 32;
	localparam int unsigned NIL = SLOTS;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned TAIL_CYCLES = 1200;

	typedef struct packed {
		action_t     act;
		logic [31:0] key;
		logic [31:0] value;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] out_key;
		logic [31:0] out_value;
		logic [5:0]  pair_count;
		logic        last;
	} response_t;

	// directed row: request plus an optional hand-typed first response
	typedef struct packed {
		request_t  req;
		logic      typed;
		response_t resp;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        m_tlast;

	array_linked_multimap #(.SLOT_COUNT(SLOTS)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// shadow copy of the slot pool
	logic [31:0] mm_key [SLOTS];
	logic [31:0] mm_val [SLOTS];
	int unsigned mm_next [SLOTS];
	int unsigned mm_prev [SLOTS];
	int unsigned mm_head, mm_tail, mm_free, mm_count;

	response_t   pending_resp [$];
	response_t   applied_first;
	int unsigned error_count;
	int unsigned sender_idle_pct, recv_stall_pct;
	bit          recv_hold;
	int unsigned idle_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic response_t mk(status_t st, logic [31:0] k, logic [31:0] v,
			logic lst);
		response_t r;
		r.status = st;
		r.out_key = k;
		r.out_value = v;
		r.pair_count = mm_count[5:0];
		r.last = lst;
		return r;
	endfunction

	function automatic void queue_resp(response_t r);
		pending_resp.insert(pending_resp.size(), r);
	endfunction

	function automatic void map_reset();
		for (int i = 0; i < SLOTS; i++) begin
			mm_key[i] = '0;
			mm_val[i] = '0;
			mm_next[i] = i + 1;
			mm_prev[i] = NIL;
		end
		mm_head = NIL;
		mm_tail = NIL;
		mm_free = 0;
		mm_count = 0;
	endfunction

	// apply one request to the shadow pool and queue the responses it causes
	function automatic void map_apply(request_t rq);
		int unsigned cur, steps, nx, pv, s, base;
		logic [31:0] seen [$];
		int n;
		n = 0;
		base = pending_resp.size();
		case (rq.act)
			ACT_ADD: begin
				s = mm_free;
				if (s >= SLOTS) begin
					queue_resp(mk(ST_FULL, '0, '0, 1'b1));
				end else begin
					mm_free = mm_next[s];
					mm_key[s] = rq.key;
					mm_val[s] = rq.value;
					mm_next[s] = NIL;
					if (mm_head >= SLOTS || mm_tail >= SLOTS) begin
						mm_head = s;
						mm_prev[s] = NIL;
					end else begin
						mm_next[mm_tail] = s;
						mm_prev[s] = mm_tail;
					end
					mm_tail = s;
					mm_count++;
					queue_resp(mk(ST_OK, '0, '0, 1'b1));
				end
			end
			ACT_REMOVE: begin
				cur = mm_head;
				steps = 0;
				while (cur < SLOTS && steps < SLOTS &&
						(mm_key[cur] != rq.key || mm_val[cur] != rq.value)) begin
					cur = mm_next[cur];
					steps++;
				end
				if (cur >= SLOTS || steps >= SLOTS) begin
					queue_resp(mk(ST_NOTFOUND, '0, '0, 1'b1));
				end else begin
					nx = mm_next[cur];
					pv = mm_prev[cur];
					if (cur == mm_head || pv >= SLOTS) begin
						mm_head = nx;
						if (nx < SLOTS) mm_prev[nx] = NIL;
					end else begin
						mm_next[pv] = nx;
						if (nx < SLOTS) mm_prev[nx] = pv;
					end
					if (nx >= SLOTS) mm_tail = (mm_head < SLOTS) ? pv : NIL;
					mm_next[cur] = mm_free;
					mm_free = cur;
					if (mm_count > 0) mm_count--;
					queue_resp(mk(ST_OK, '0, '0, 1'b1));
				end
			end
			ACT_SEARCH: begin
				cur = mm_head;
				steps = 0;
				while (cur < SLOTS && steps < SLOTS) begin
					if (mm_key[cur] == rq.key) begin
						queue_resp(mk(ST_OK, '0, mm_val[cur], 1'b0));
						n++;
					end
					cur = mm_next[cur];
					steps++;
				end
				if (n == 0) queue_resp(mk(ST_NOTFOUND, '0, '0, 1'b1));
				else pending_resp[$].last = 1'b1;
			end
			default: begin
				cur = mm_head;
				steps = 0;
				while (cur < SLOTS && steps < SLOTS) begin
					bit hit;
					hit = 1'b0;
					foreach (seen[i]) if (seen[i] == mm_key[cur]) hit = 1'b1;
					if (!hit && seen.size() < SLOTS) begin
						seen.insert(seen.size(), mm_key[cur]);
						queue_resp(mk(ST_OK, mm_key[cur], '0, 1'b0));
						n++;
					end
					cur = mm_next[cur];
					steps++;
				end
				if (n == 0) queue_resp(mk(ST_NOTFOUND, '0, '0, 1'b1));
				else pending_resp[$].last = 1'b1;
			end
		endcase
		applied_first = pending_resp[base];
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// result side: compare every accepted response with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			response_t got, want;
			got.status = status_t'(m_tdata[1:0]);
			got.out_key = m_tdata[33:2];
			got.out_value = m_tdata[65:34];
			got.pair_count = m_tdata[71:66];
			got.last = m_tlast;
			if (pending_resp.size() == 0) begin
				report_mismatch("unexpected response", m_tdata[31:0], '0);
			end else begin
				want = pending_resp.pop_front();
				if (got.status != want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
				if (got.out_key != want.out_key)
					report_mismatch("out_key", got.out_key, want.out_key);
				if (got.out_value != want.out_value)
					report_mismatch("out_value", got.out_value, want.out_value);
				if (got.pair_count != want.pair_count)
					report_mismatch("pair_count", 32'(got.pair_count),
						32'(want.pair_count));
				if (got.last != want.last)
					report_mismatch("last", 32'(got.last), 32'(want.last));
			end
		end
	end

	// receiver stalls, with an occasional long hold-off
	always @(negedge clk) begin
		if (recv_hold) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired at %0t", $realtime);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// offer one request and wait for its acceptance; the predictor's first
	// response for it is kept for typed rows
	task automatic send_request(request_t rq);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {6'd0, rq.value, rq.key, rq.act};
		do @(posedge clk); while (!s_tready);
		map_apply(rq);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic drain();
		while (pending_resp.size() != 0) @(negedge clk);
	endtask

	function automatic request_t pick_request(logic [31:0] pool []);
		request_t rq;
		int unsigned r, cur;
		r = $urandom_range(99);
		rq.key = pool[$urandom_range(pool.size() - 1)];
		rq.value = $urandom_range(3);
		if (r < 3) rq.value = $urandom;
		if (r < 45) rq.act = ACT_ADD;
		else if (r < 70) rq.act = ACT_REMOVE;
		else if (r < 88) rq.act = ACT_SEARCH;
		else rq.act = ACT_KEYS;
		// most removes name a stored pair
		if (rq.act == ACT_REMOVE && mm_count > 0 && $urandom_range(3) != 0) begin
			cur = mm_head;
			repeat ($urandom_range(mm_count - 1)) cur = mm_next[cur];
			rq.key = mm_key[cur];
			rq.value = mm_val[cur];
		end
		return rq;
	endfunction

	row_t rows [$];
	logic [31:0] key_pool [];

	task automatic add_row(action_t a, logic [31:0] k, logic [31:0] v, logic t,
			status_t st, logic [5:0] cnt);
		row_t rw;
		rw.req = '{a, k, v};
		rw.typed = t;
		rw.resp = '{st, 32'd0, 32'd0, cnt, 1'b1};
		rows.insert(rows.size(), rw);
	endtask

	initial begin
		response_t first;
		s_tvalid = 1'b0;
		s_tdata = '0;
		recv_hold = 1'b0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		error_count = 0;
		arst_n = 1'b0;
		map_reset();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed table: empty cases, extremes, duplicates, removal of head and tail
		add_row(ACT_KEYS, 32'd0, 32'd0, 1'b1, ST_NOTFOUND, 6'd0);
		add_row(ACT_SEARCH, 32'h8000_0000, 32'd0, 1'b1, ST_NOTFOUND, 6'd0);
		add_row(ACT_REMOVE, 32'd0, 32'd0, 1'b1, ST_NOTFOUND, 6'd0);
		add_row(ACT_ADD, 32'h8000_0000, 32'h7fff_ffff, 1'b1, ST_OK, 6'd1);
		add_row(ACT_ADD, 32'h7fff_ffff, 32'h8000_0000, 1'b1, ST_OK, 6'd2);
		add_row(ACT_ADD, 32'h8000_0000, 32'hffff_ffff, 1'b1, ST_OK, 6'd3);
		add_row(ACT_ADD, 32'hffff_ffff, 32'h0000_0000, 1'b1, ST_OK, 6'd4);
		add_row(ACT_SEARCH, 32'h8000_0000, 32'd0, 1'b0, ST_OK, 6'd0);
		add_row(ACT_KEYS, 32'd0, 32'd0, 1'b0, ST_OK, 6'd0);
		add_row(ACT_REMOVE, 32'h8000_0000, 32'h0, 1'b1, ST_NOTFOUND, 6'd4);
		add_row(ACT_REMOVE, 32'hffff_ffff, 32'h0, 1'b1, ST_OK, 6'd3);
		add_row(ACT_ADD, 32'h5555_aaaa, 32'haaaa_5555, 1'b1, ST_OK, 6'd4);
		add_row(ACT_REMOVE, 32'h8000_0000, 32'h7fff_ffff, 1'b1, ST_OK, 6'd3);
		add_row(ACT_REMOVE, 32'h7fff_ffff, 32'h8000_0000, 1'b0, ST_OK, 6'd0);
		add_row(ACT_KEYS, 32'd0, 32'd0, 1'b0, ST_OK, 6'd0);
		add_row(ACT_REMOVE, 32'h5555_aaaa, 32'haaaa_5555, 1'b0, ST_OK, 6'd0);
		add_row(ACT_REMOVE, 32'h8000_0000, 32'hffff_ffff, 1'b1, ST_OK, 6'd0);
		add_row(ACT_ADD, 32'h0000_0001, 32'h0000_0002, 1'b1, ST_OK, 6'd1);
		add_row(ACT_SEARCH, 32'h0000_0001, 32'd0, 1'b0, ST_OK, 6'd0);
		foreach (rows[i]) begin
			send_request(rows[i].req);
			if (rows[i].typed) begin
				first = applied_first;
				if (first != rows[i].resp)
					report_mismatch("typed row", first[31:0], rows[i].resp[31:0]);
			end
		end
		drain();

		// fill to capacity, then hit the full case and empty again
		repeat (SLOTS + 2) send_request('{ACT_ADD, $urandom, $urandom});
		send_request('{ACT_SEARCH, mm_key[mm_tail], 32'd0});
		send_request('{ACT_KEYS, 32'd0, 32'd0});
		// long receiver hold-off while requests keep coming
		fork
			begin
				recv_hold = 1'b1;
				repeat (400) @(negedge clk);
				recv_hold = 1'b0;
			end
			repeat (6) send_request('{ACT_KEYS, 32'd0, 32'd0});
		join
		drain();
		while (mm_count > 0) send_request('{ACT_REMOVE, mm_key[mm_head], mm_val[mm_head]});
		drain();

		// random part over small key pools to get duplicates and matches
		key_pool = new[6];
		foreach (key_pool[i]) key_pool[i] = $urandom;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin sender_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			repeat (10) send_request(pick_request(key_pool));
			drain();
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule
